// ===== rtl/gn3_pkg.sv =====
`timescale 1ns / 1ps

package gn3_pkg;

  // Field widths of the transactions.
  localparam int COORD_W = 20;
  localparam int FRAC_W  = 8;
  localparam int CELL_W  = 12;
  localparam int TBL_W   = 4;
  localparam int GRAD_W  = 16;
  localparam int GVEC_W  = 3 * GRAD_W;
  localparam int FADE_W  = 16;
  localparam int OUT_W   = 16;

  // Dot products and blend values are kept in Q.22 with this width.
  localparam int DOT_W   = 28;

  // Shift of the reciprocal used to reduce cells to the lattice.
  localparam int RECIP_SHIFT = 24;

  // Request codes on req_type.
  typedef enum logic [1:0] {
    REQ_EVAL = 2'd0,
    REQ_PERM = 2'd1,
    REQ_GRAD = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  // Control that travels with each transaction through the pipeline.
  typedef struct packed {
    logic valid;
    logic eval;
    logic perm_we;
    logic grad_we;
  } ctrl_t;

endpackage

// ===== rtl/gn3_ram.sv =====
`timescale 1ns / 1ps

module gn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gn3_coord.sv =====
`timescale 1ns / 1ps

module gn3_coord #(
  parameter int LATTICE_SIZE = 16,
  localparam int AW = $clog2(LATTICE_SIZE)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic [1:0]                            req_type,
  input  logic signed [gn3_pkg::COORD_W-1:0]    coord_x,
  input  logic signed [gn3_pkg::COORD_W-1:0]    coord_y,
  input  logic signed [gn3_pkg::COORD_W-1:0]    coord_z,
  input  logic [gn3_pkg::TBL_W-1:0]             table_index,
  input  logic [gn3_pkg::TBL_W-1:0]             perm_value,
  input  logic signed [gn3_pkg::GRAD_W-1:0]     grad_x,
  input  logic signed [gn3_pkg::GRAD_W-1:0]     grad_y,
  input  logic signed [gn3_pkg::GRAD_W-1:0]     grad_z,
  output gn3_pkg::ctrl_t                        s4_ctrl,
  output logic [2:0][AW-1:0]                    s4_c0,
  output logic [2:0][AW-1:0]                    s4_c1,
  output logic [2:0][gn3_pkg::FRAC_W-1:0]       s4_t,
  output logic [2:0][gn3_pkg::FADE_W-1:0]       s4_u,
  output logic [AW-1:0]                         s4_waddr,
  output logic [AW-1:0]                         s4_pval,
  output logic [gn3_pkg::GVEC_W-1:0]            s4_grad
);

  localparam int CW = gn3_pkg::CELL_W;
  localparam int FW = gn3_pkg::FRAC_W;
  localparam int RECIP = ((1 << gn3_pkg::RECIP_SHIFT) + LATTICE_SIZE - 1) / LATTICE_SIZE;
  localparam logic [24:0] RECIP_V = 25'(RECIP);
  localparam logic [8:0] LAT = 9'(LATTICE_SIZE);
  localparam logic [AW:0] LAT_A = (AW+1)'(LATTICE_SIZE);
  localparam logic [AW:0] KOFF = (AW+1)'((1 << (CW - 1)) % LATTICE_SIZE);

  gn3_pkg::ctrl_t in_ctrl;
  logic [8:0] pv_red;
  logic [2:0][gn3_pkg::COORD_W-1:0] coord;

  gn3_pkg::ctrl_t s1_ctrl, s2_ctrl, s3_ctrl;
  logic [2:0][CW-1:0] s1_v, s2_v;
  logic [2:0][FW-1:0] s1_t, s2_t, s3_t;
  logic [2:0][CW-1:0] s2_q;
  logic [2:0][15:0] s2_tt;
  logic [2:0][AW-1:0] s3_r;
  logic [2:0][gn3_pkg::FADE_W-1:0] s3_u;
  logic [AW-1:0] s1_waddr, s2_waddr, s3_waddr;
  logic [AW-1:0] s1_pval, s2_pval, s3_pval;
  logic [gn3_pkg::GVEC_W-1:0] s1_grad, s2_grad, s3_grad;

  logic [2:0][36:0] q_prod;
  logic [2:0][20:0] ql_prod;
  logic [2:0][CW-1:0] r_full;
  logic [2:0][25:0] f_prod;
  logic [2:0][26:0] f_rnd;
  logic [2:0][AW:0] c0_w;
  logic [2:0][AW-1:0] c0_next, c1_next;

  // Decode the incoming transaction and reduce the permutation value to the lattice.
  always_comb begin
    coord = {coord_z, coord_y, coord_x};
    in_ctrl.valid = in_valid;
    in_ctrl.eval = in_valid && (gn3_pkg::req_t'(req_type) == gn3_pkg::REQ_EVAL);
    in_ctrl.perm_we = in_valid && (gn3_pkg::req_t'(req_type) == gn3_pkg::REQ_PERM) &&
                      ({5'b0, table_index} < LAT);
    in_ctrl.grad_we = in_valid && (gn3_pkg::req_t'(req_type) == gn3_pkg::REQ_GRAD) &&
                      ({5'b0, table_index} < LAT);
    pv_red = 9'(perm_value);
    for (int i = 0; i < 8; i++) begin
      if (pv_red >= LAT) begin
        pv_red = pv_red - LAT;
      end
    end
  end

  // Cell reduction by reciprocal, fade polynomial and corner wrap for each axis.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q_prod[k] = 37'(s1_v[k]) * 37'(RECIP_V);
      ql_prod[k] = 21'(s2_q[k]) * 21'(LAT);
      r_full[k] = s2_v[k] - ql_prod[k][CW-1:0];
      f_prod[k] = 26'(s2_tt[k]) * 26'(10'd768 - {1'b0, s2_t[k], 1'b0});
      f_rnd[k] = 27'(f_prod[k]) + 27'd128;
      c0_w[k] = ({1'b0, s3_r[k]} >= KOFF) ? ({1'b0, s3_r[k]} - KOFF)
                                          : ({1'b0, s3_r[k]} + LAT_A - KOFF);
      c0_next[k] = c0_w[k][AW-1:0];
      c1_next[k] = (c0_next[k] == AW'(LATTICE_SIZE - 1)) ? '0 : c0_next[k] + 1'b1;
    end
  end

  // Valid bits of the first four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
      s2_ctrl <= '0;
      s3_ctrl <= '0;
      s4_ctrl <= '0;
    end else if (adv) begin
      s1_ctrl <= in_ctrl;
      s2_ctrl <= s1_ctrl;
      s3_ctrl <= s2_ctrl;
      s4_ctrl <= s3_ctrl;
    end
  end

  // Payload of the first four stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        // The cell is offset by half its range so that it is never negative.
        s1_v[k] <= {~coord[k][gn3_pkg::COORD_W-1], coord[k][gn3_pkg::COORD_W-2:FW]};
        s1_t[k] <= coord[k][FW-1:0];
        s2_v[k] <= s1_v[k];
        s2_t[k] <= s1_t[k];
        s2_q[k] <= q_prod[k][gn3_pkg::RECIP_SHIFT +: CW];
        s2_tt[k] <= 16'(s1_t[k]) * 16'(s1_t[k]);
        s3_t[k] <= s2_t[k];
        s3_r[k] <= r_full[k][AW-1:0];
        s3_u[k] <= f_rnd[k][23:8];
        s4_t[k] <= s3_t[k];
        s4_u[k] <= s3_u[k];
        s4_c0[k] <= c0_next[k];
        s4_c1[k] <= c1_next[k];
      end
      s1_waddr <= AW'(table_index);
      s1_pval <= pv_red[AW-1:0];
      s1_grad <= {grad_z, grad_y, grad_x};
      s2_waddr <= s1_waddr;
      s2_pval <= s1_pval;
      s2_grad <= s1_grad;
      s3_waddr <= s2_waddr;
      s3_pval <= s2_pval;
      s3_grad <= s2_grad;
      s4_waddr <= s3_waddr;
      s4_pval <= s3_pval;
      s4_grad <= s3_grad;
    end
  end

endmodule

// ===== rtl/gn3_hash.sv =====
`timescale 1ns / 1ps

module gn3_hash #(
  parameter int LATTICE_SIZE = 16,
  localparam int AW = $clog2(LATTICE_SIZE)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  gn3_pkg::ctrl_t                        s4_ctrl,
  input  logic [2:0][AW-1:0]                    s4_c0,
  input  logic [2:0][AW-1:0]                    s4_c1,
  input  logic [2:0][gn3_pkg::FRAC_W-1:0]       s4_t,
  input  logic [2:0][gn3_pkg::FADE_W-1:0]       s4_u,
  input  logic [AW-1:0]                         s4_waddr,
  input  logic [AW-1:0]                         s4_pval,
  input  logic [gn3_pkg::GVEC_W-1:0]            s4_grad,
  output gn3_pkg::ctrl_t                        s8_ctrl,
  output logic [2:0][gn3_pkg::FRAC_W-1:0]       s8_t,
  output logic [2:0][gn3_pkg::FADE_W-1:0]       s8_u,
  output logic [7:0][gn3_pkg::GVEC_W-1:0]       s8_grad
);

  localparam logic [AW:0] LAT_A = (AW+1)'(LATTICE_SIZE);

  gn3_pkg::ctrl_t s5_ctrl, s6_ctrl, s7_ctrl;
  logic [2:0][AW-1:0] s5_c0, s5_c1, s6_c0, s6_c1;
  logic [2:0][gn3_pkg::FRAC_W-1:0] s5_t, s6_t, s7_t;
  logic [2:0][gn3_pkg::FADE_W-1:0] s5_u, s6_u, s7_u;
  logic [AW-1:0] s5_waddr, s6_waddr, s7_waddr;
  logic [AW-1:0] s5_pval, s6_pval;
  logic [gn3_pkg::GVEC_W-1:0] s5_grad, s6_grad, s7_grad;

  logic [AW-1:0] p1 [2];
  logic [AW-1:0] p2 [4];
  logic [AW-1:0] p3 [8];
  logic [AW-1:0] a2 [4];
  logic [AW-1:0] a3 [8];
  logic [gn3_pkg::GVEC_W-1:0] gr [8];

  function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= LAT_A) begin
      s = s - LAT_A;
    end
    return s[AW-1:0];
  endfunction

  // Each hash level has its own copies of the permutation table. A load writes
  // them at the stage where evaluations read them, so transaction order holds.
  for (genvar i = 0; i < 2; i++) begin : g_lvl1
    gn3_ram #(.WIDTH(AW), .DEPTH(LATTICE_SIZE)) u_perm (
      .clk   (clk),
      .we    (adv && s4_ctrl.perm_we),
      .waddr (s4_waddr),
      .wdata (s4_pval),
      .re    (adv),
      .raddr ((i == 0) ? s4_c0[0] : s4_c1[0]),
      .rdata (p1[i])
    );
  end

  // Second level: corner index bit 0 selects x, bit 1 selects y.
  for (genvar j = 0; j < 4; j++) begin : g_lvl2
    assign a2[j] = add_mod(p1[j % 2], ((j / 2) == 0) ? s5_c0[1] : s5_c1[1]);
    gn3_ram #(.WIDTH(AW), .DEPTH(LATTICE_SIZE)) u_perm (
      .clk   (clk),
      .we    (adv && s5_ctrl.perm_we),
      .waddr (s5_waddr),
      .wdata (s5_pval),
      .re    (adv),
      .raddr (a2[j]),
      .rdata (p2[j])
    );
  end

  // Third level: corner index bit 2 selects z.
  for (genvar k = 0; k < 8; k++) begin : g_lvl3
    assign a3[k] = add_mod(p2[k % 4], ((k / 4) == 0) ? s6_c0[2] : s6_c1[2]);
    gn3_ram #(.WIDTH(AW), .DEPTH(LATTICE_SIZE)) u_perm (
      .clk   (clk),
      .we    (adv && s6_ctrl.perm_we),
      .waddr (s6_waddr),
      .wdata (s6_pval),
      .re    (adv),
      .raddr (a3[k]),
      .rdata (p3[k])
    );
  end

  // Gradient lookup, one table copy per corner.
  for (genvar k = 0; k < 8; k++) begin : g_grad
    gn3_ram #(.WIDTH(gn3_pkg::GVEC_W), .DEPTH(LATTICE_SIZE)) u_grad (
      .clk   (clk),
      .we    (adv && s7_ctrl.grad_we),
      .waddr (s7_waddr),
      .wdata (s7_grad),
      .re    (adv),
      .raddr (p3[k]),
      .rdata (gr[k])
    );
    assign s8_grad[k] = gr[k];
  end

  // Valid bits of the hash stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_ctrl <= '0;
      s6_ctrl <= '0;
      s7_ctrl <= '0;
      s8_ctrl <= '0;
    end else if (adv) begin
      s5_ctrl <= s4_ctrl;
      s6_ctrl <= s5_ctrl;
      s7_ctrl <= s6_ctrl;
      s8_ctrl <= s7_ctrl;
    end
  end

  // Payload that rides alongside the table reads.
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_c0 <= s4_c0;
      s5_c1 <= s4_c1;
      s6_c0 <= s5_c0;
      s6_c1 <= s5_c1;
      s5_t <= s4_t;
      s6_t <= s5_t;
      s7_t <= s6_t;
      s8_t <= s7_t;
      s5_u <= s4_u;
      s6_u <= s5_u;
      s7_u <= s6_u;
      s8_u <= s7_u;
      s5_waddr <= s4_waddr;
      s6_waddr <= s5_waddr;
      s7_waddr <= s6_waddr;
      s5_pval <= s4_pval;
      s6_pval <= s5_pval;
      s5_grad <= s4_grad;
      s6_grad <= s5_grad;
      s7_grad <= s6_grad;
    end
  end

endmodule

// ===== rtl/gn3_blend.sv =====
`timescale 1ns / 1ps

module gn3_blend (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  gn3_pkg::ctrl_t                        s8_ctrl,
  input  logic [2:0][gn3_pkg::FRAC_W-1:0]       s8_t,
  input  logic [2:0][gn3_pkg::FADE_W-1:0]       s8_u,
  input  logic [7:0][gn3_pkg::GVEC_W-1:0]       s8_grad,
  output logic                                  out_valid,
  output logic signed [gn3_pkg::OUT_W-1:0]      noise_value
);

  localparam int DW = gn3_pkg::DOT_W;
  localparam int GW = gn3_pkg::GRAD_W;
  localparam int PW = GW + gn3_pkg::FRAC_W + 1;

  gn3_pkg::ctrl_t s9_ctrl, s10_ctrl, s11_ctrl, s12_ctrl, s13_ctrl;
  logic [2:0][gn3_pkg::FADE_W-1:0] s9_u, s10_u, s11_u, s12_u;
  logic signed [PW-1:0] prod_next [8][3];
  logic signed [PW-1:0] s9_prod [8][3];
  logic signed [DW-1:0] s10_dot [8];
  logic signed [DW-1:0] s11_e [4];
  logic signed [DW-1:0] s12_f [2];
  logic signed [DW-1:0] s13_g;
  logic signed [DW-1:0] rnd;
  logic signed [DW-1:0] shifted;

  // Linear blend a + (b - a) * u, rounded half up at 16 fraction bits.
  function automatic logic signed [DW-1:0] lerp(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b,
                                                input logic [gn3_pkg::FADE_W-1:0] u);
    logic signed [DW:0] diff;
    logic signed [DW+17:0] prod;
    logic signed [DW+17:0] sh;
    diff = (DW+1)'(b) - (DW+1)'(a);
    prod = (DW+18)'(diff) * (DW+18)'($signed({1'b0, u}));
    sh = (prod + (DW+18)'(1 << 15)) >>> 16;
    return DW'(a + DW'(sh));
  endfunction

  // Gradient component times corner offset; the far corner offset is t - 256.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      for (int a = 0; a < 3; a++) begin
        prod_next[k][a] = PW'($signed(s8_grad[k][a*GW +: GW])) *
                          PW'($signed({((k >> a) & 1) == 1, s8_t[a]}));
      end
    end
  end

  // Output rounding to Q2.14; saturation is applied at the output register.
  always_comb begin
    rnd = s13_g + DW'(128);
    shifted = rnd >>> 8;
  end

  // Valid bits of the blend stages and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s9_ctrl <= '0;
      s10_ctrl <= '0;
      s11_ctrl <= '0;
      s12_ctrl <= '0;
      s13_ctrl <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s9_ctrl <= s8_ctrl;
      s10_ctrl <= s9_ctrl;
      s11_ctrl <= s10_ctrl;
      s12_ctrl <= s11_ctrl;
      s13_ctrl <= s12_ctrl;
      out_valid <= s13_ctrl.eval;
    end
  end

  // Dot products, then the x, y and z blends, one stage each, then the saturated output.
  always_ff @(posedge clk) begin
    if (adv) begin
      s9_prod <= prod_next;
      s9_u <= s8_u;
      s10_u <= s9_u;
      s11_u <= s10_u;
      s12_u <= s11_u;
      for (int k = 0; k < 8; k++) begin
        s10_dot[k] <= DW'(s9_prod[k][0]) + DW'(s9_prod[k][1]) + DW'(s9_prod[k][2]);
      end
      for (int j = 0; j < 4; j++) begin
        s11_e[j] <= lerp(s10_dot[2*j], s10_dot[2*j+1], s10_u[0]);
      end
      for (int m = 0; m < 2; m++) begin
        s12_f[m] <= lerp(s11_e[2*m], s11_e[2*m+1], s11_u[1]);
      end
      s13_g <= lerp(s12_f[0], s12_f[1], s12_u[2]);
      if (shifted > DW'(32767)) begin
        noise_value <= 16'sh7fff;
      end else if (shifted < -DW'(32768)) begin
        noise_value <= -16'sh8000;
      end else begin
        noise_value <= shifted[gn3_pkg::OUT_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/gradient_noise_3d.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per cycle; the whole 14-stage pipeline moves as one,
// held only while a finished result waits on out_stall.
// Load transactions travel the same pipeline and write the tables without a result.
// Reset clears every valid bit; table contents stay undefined until loaded.

module gradient_noise_3d #(
  parameter int LATTICE_SIZE = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            req_type,
  input  logic signed [gn3_pkg::COORD_W-1:0]    coord_x,
  input  logic signed [gn3_pkg::COORD_W-1:0]    coord_y,
  input  logic signed [gn3_pkg::COORD_W-1:0]    coord_z,
  input  logic [gn3_pkg::TBL_W-1:0]             table_index,
  input  logic [gn3_pkg::TBL_W-1:0]             perm_value,
  input  logic signed [gn3_pkg::GRAD_W-1:0]     grad_x,
  input  logic signed [gn3_pkg::GRAD_W-1:0]     grad_y,
  input  logic signed [gn3_pkg::GRAD_W-1:0]     grad_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gn3_pkg::OUT_W-1:0]      noise_value
);

  localparam int AW = $clog2(LATTICE_SIZE);

  logic adv;
  gn3_pkg::ctrl_t s4_ctrl, s8_ctrl;
  logic [2:0][AW-1:0] s4_c0, s4_c1;
  logic [2:0][gn3_pkg::FRAC_W-1:0] s4_t, s8_t;
  logic [2:0][gn3_pkg::FADE_W-1:0] s4_u, s8_u;
  logic [AW-1:0] s4_waddr, s4_pval;
  logic [gn3_pkg::GVEC_W-1:0] s4_grad;
  logic [7:0][gn3_pkg::GVEC_W-1:0] s8_grad;

  // The pipeline advances unless a result is held at the output.
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  gn3_coord #(.LATTICE_SIZE(LATTICE_SIZE)) u_coord (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (in_valid),
    .req_type    (req_type),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .table_index (table_index),
    .perm_value  (perm_value),
    .grad_x      (grad_x),
    .grad_y      (grad_y),
    .grad_z      (grad_z),
    .s4_ctrl     (s4_ctrl),
    .s4_c0       (s4_c0),
    .s4_c1       (s4_c1),
    .s4_t        (s4_t),
    .s4_u        (s4_u),
    .s4_waddr    (s4_waddr),
    .s4_pval     (s4_pval),
    .s4_grad     (s4_grad)
  );

  gn3_hash #(.LATTICE_SIZE(LATTICE_SIZE)) u_hash (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .s4_ctrl  (s4_ctrl),
    .s4_c0    (s4_c0),
    .s4_c1    (s4_c1),
    .s4_t     (s4_t),
    .s4_u     (s4_u),
    .s4_waddr (s4_waddr),
    .s4_pval  (s4_pval),
    .s4_grad  (s4_grad),
    .s8_ctrl  (s8_ctrl),
    .s8_t     (s8_t),
    .s8_u     (s8_u),
    .s8_grad  (s8_grad)
  );

  gn3_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .s8_ctrl     (s8_ctrl),
    .s8_t        (s8_t),
    .s8_u        (s8_u),
    .s8_grad     (s8_grad),
    .out_valid   (out_valid),
    .noise_value (noise_value)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int COORD_W = gn3_pkg::COORD_W;
  localparam int TBL_W   = gn3_pkg::TBL_W;
  localparam int GRAD_W  = gn3_pkg::GRAD_W;
  localparam int OUT_W   = gn3_pkg::OUT_W;

  // One input transaction as offered to the block.
  typedef struct {
    gn3_pkg::req_t             kind;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic [TBL_W-1:0]          idx, pval;
    logic signed [GRAD_W-1:0]  gx, gy, gz;
  } noise_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = gn3_pkg::REQ_NONE;
  logic signed [COORD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [TBL_W-1:0] table_index = '0, perm_value = '0;
  logic signed [GRAD_W-1:0] grad_x = '0, grad_y = '0, grad_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] noise_value;

  gradient_noise_3d dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the lattice tables.
  logic [TBL_W-1:0]         perm_tbl [16];
  logic signed [GRAD_W-1:0] grad_tbl [16][3];

  noise_req_t        pending_reqs[$];
  logic [OUT_W-1:0]  expected_noise[$];
  int mismatches = 0;
  int noise_seen = 0;
  int evals_sent = 0;
  int loads_sent = 0;
  int stall_events = 0;
  bit accepted_last = 1'b0;

  function automatic int hash_corner(int x, int y, int z);
    return int'(perm_tbl[(int'(perm_tbl[(int'(perm_tbl[x]) + y) % 16]) + z) % 16]);
  endfunction

  function automatic longint fade_weight(longint t);
    return (t * t * (768 - 2 * t) + 128) >> 8;
  endfunction

  function automatic longint blend(longint a, longint b, longint u);
    return (a * (65536 - u) + b * u + 32768) >>> 16;
  endfunction

  function automatic longint corner_dot(int x, int y, int z, longint ox, longint oy,
                                        longint oz);
    int h;
    h = hash_corner(x, y, z);
    return grad_tbl[h][0] * ox + grad_tbl[h][1] * oy + grad_tbl[h][2] * oz;
  endfunction

  // Computes the expected noise value at one point from the current tables.
  function automatic logic [OUT_W-1:0] noise_at(noise_req_t r);
    logic [COORD_W-1:0] raw [3];
    int c0 [3], c1 [3];
    longint lo [3], hi [3], w [3];
    longint a, b, c, d, e, f, g, res;
    raw[0] = r.cx; raw[1] = r.cy; raw[2] = r.cz;
    for (int k = 0; k < 3; k++) begin
      // Low four cell bits give the lattice index, negative cells included.
      c0[k] = int'(raw[k][11:8]);
      c1[k] = (c0[k] + 1) % 16;
      lo[k] = longint'(raw[k][7:0]);
      hi[k] = lo[k] - 256;
      w[k]  = fade_weight(lo[k]);
    end
    a = blend(corner_dot(c0[0], c0[1], c0[2], lo[0], lo[1], lo[2]),
              corner_dot(c1[0], c0[1], c0[2], hi[0], lo[1], lo[2]), w[0]);
    b = blend(corner_dot(c0[0], c1[1], c0[2], lo[0], hi[1], lo[2]),
              corner_dot(c1[0], c1[1], c0[2], hi[0], hi[1], lo[2]), w[0]);
    c = blend(corner_dot(c0[0], c0[1], c1[2], lo[0], lo[1], hi[2]),
              corner_dot(c1[0], c0[1], c1[2], hi[0], lo[1], hi[2]), w[0]);
    d = blend(corner_dot(c0[0], c1[1], c1[2], lo[0], hi[1], hi[2]),
              corner_dot(c1[0], c1[1], c1[2], hi[0], hi[1], hi[2]), w[0]);
    e = blend(a, b, w[1]);
    f = blend(c, d, w[1]);
    g = blend(e, f, w[2]);
    res = (g + 128) >>> 8;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[OUT_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic noise_req_t eval_req(int x, int y, int z);
    noise_req_t r;
    r = '{kind: gn3_pkg::REQ_EVAL, cx: COORD_W'(x), cy: COORD_W'(y), cz: COORD_W'(z),
          idx: TBL_W'($urandom), pval: TBL_W'($urandom),
          gx: GRAD_W'($urandom), gy: GRAD_W'($urandom), gz: GRAD_W'($urandom)};
    return r;
  endfunction

  function automatic noise_req_t perm_req(int i, int v);
    noise_req_t r;
    r = eval_req($urandom, $urandom, $urandom);
    r.kind = gn3_pkg::REQ_PERM; r.idx = TBL_W'(i); r.pval = TBL_W'(v);
    return r;
  endfunction

  function automatic noise_req_t grad_req(int i, int x, int y, int z);
    noise_req_t r;
    r = eval_req($urandom, $urandom, $urandom);
    r.kind = gn3_pkg::REQ_GRAD; r.idx = TBL_W'(i);
    r.gx = GRAD_W'(x); r.gy = GRAD_W'(y); r.gz = GRAD_W'(z);
    return r;
  endfunction

  function automatic int grad_comp();
    if ($urandom_range(0, 9) == 0) return $signed(16'($urandom));
    return $urandom_range(0, 32768) - 16384;
  endfunction

  // Driver: offers pending transactions at the falling edge.
  int gap = 0;
  always @(negedge clk) begin
    if (!rst && (!in_valid || accepted_last)) begin
      if (gap > 0) begin
        in_valid <= 1'b0;
        gap--;
      end else if (pending_reqs.size() > 0) begin
        noise_req_t r;
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        req_type <= r.kind;
        coord_x <= r.cx; coord_y <= r.cy; coord_z <= r.cz;
        table_index <= r.idx; perm_value <= r.pval;
        grad_x <= r.gx; grad_y <= r.gy; grad_z <= r.gz;
        gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Input acceptance: update the local tables or predict a noise value.
  always @(posedge clk) begin
    accepted_last <= in_valid && !in_stall && !rst;
    if (in_valid && in_stall && !rst) stall_events++;
    if (in_valid && !in_stall && !rst) begin
      noise_req_t r;
      r = '{kind: gn3_pkg::req_t'(req_type), cx: coord_x, cy: coord_y, cz: coord_z,
            idx: table_index, pval: perm_value, gx: grad_x, gy: grad_y, gz: grad_z};
      case (r.kind)
        gn3_pkg::REQ_PERM: begin
          perm_tbl[r.idx] = r.pval;
          loads_sent++;
        end
        gn3_pkg::REQ_GRAD: begin
          grad_tbl[r.idx][0] = r.gx;
          grad_tbl[r.idx][1] = r.gy;
          grad_tbl[r.idx][2] = r.gz;
          loads_sent++;
        end
        gn3_pkg::REQ_EVAL: begin
          expected_noise.push_back(noise_at(r));
          evals_sent++;
        end
        default: ;
      endcase
    end
  end

  // Receiver back-pressure, with one long hold-off to fill the pipeline.
  int hold_cnt = 0;
  bit held_once = 1'b0;
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else if (!held_once && noise_seen >= 60) begin
      held_once = 1'b1;
      hold_cnt = 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 20);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_noise.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: noise_value=%0d", noise_value);
      end else begin
        logic [OUT_W-1:0] exp_v;
        exp_v = expected_noise.pop_front();
        if (noise_value !== exp_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch on noise_value: expected %0d, actual %0d",
                     $signed(exp_v), noise_value);
        end
      end
      noise_seen++;
    end
  end

  // Stimulus: fill the tables, directed corner cases, then random traffic.
  initial begin
    int r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 16; i++) pending_reqs.push_back(perm_req(i, (i * 7 + 3) % 16));
    for (int i = 0; i < 16; i++)
      pending_reqs.push_back(grad_req(i, grad_comp(), grad_comp(), grad_comp()));
    // Coordinate extremes, zero fractions, full fractions and negative cells.
    pending_reqs.push_back(eval_req(0, 0, 0));
    pending_reqs.push_back(eval_req(524287, 524287, 524287));
    pending_reqs.push_back(eval_req(-524288, -524288, -524288));
    pending_reqs.push_back(eval_req(255, 128, 1));
    pending_reqs.push_back(eval_req(-1, -256, -129));
    pending_reqs.push_back(eval_req(-524288, 524287, 0));
    // An ignored request type, then steep gradients that drive saturation.
    begin
      noise_req_t n;
      n = eval_req(300, 300, 300);
      n.kind = gn3_pkg::REQ_NONE;
      pending_reqs.push_back(n);
    end
    for (int i = 0; i < 16; i++) pending_reqs.push_back(grad_req(i, 16384, 16384, 16384));
    pending_reqs.push_back(eval_req(128, 128, 128));
    pending_reqs.push_back(eval_req(-128, -128, -128));
    for (int i = 0; i < 16; i++) pending_reqs.push_back(grad_req(i, -32768, 32767, -32768));
    pending_reqs.push_back(eval_req(200, 60, 200));
    for (int i = 0; i < 16; i++)
      pending_reqs.push_back(grad_req(i, grad_comp(), grad_comp(), grad_comp()));
    // Random mix, mostly evaluations.
    for (int n = 0; n < 360; n++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        if ($urandom_range(0, 3) == 0)
          pending_reqs.push_back(eval_req($urandom, $urandom, $urandom));
        else
          pending_reqs.push_back(eval_req($urandom_range(0, 8191) - 4096,
                                          $urandom_range(0, 8191) - 4096,
                                          $urandom_range(0, 8191) - 4096));
      end else if (r < 85) begin
        pending_reqs.push_back(perm_req($urandom_range(0, 15), $urandom_range(0, 15)));
      end else if (r < 96) begin
        pending_reqs.push_back(grad_req($urandom_range(0, 15), grad_comp(), grad_comp(),
                                        grad_comp()));
      end else begin
        noise_req_t n;
        n = eval_req($urandom, $urandom, $urandom);
        n.kind = gn3_pkg::REQ_NONE;
        pending_reqs.push_back(n);
      end
    end
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_noise.size() == 0);
    repeat (40) @(posedge clk);
    $display("Covered %0d evaluations and %0d table loads; %0d results checked.",
             evals_sent, loads_sent, noise_seen);
    $display("Input held off for %0d cycles; %0d mismatches.", stall_events, mismatches);
    if (mismatches == 0 && expected_noise.size() == 0)
      $display("PASS gradient_noise_3d");
    else
      $display("FAIL gradient_noise_3d");
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding.", expected_noise.size());
    $display("FAIL gradient_noise_3d");
    $finish;
  end

endmodule
